@@ src/blid_pkg.sv @@
// Shared types and constants for the bounded list insert/delete unit.
// Word layouts for both channels, cell command codes and sizing constants.
// No dependencies.
`default_nettype none

package blid_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 32;

  localparam logic [1:0] MODE_FRONT = 2'd0;
  localparam logic [1:0] MODE_BACK  = 2'd1;
  localparam int unsigned MODE_DELETE_BIT = 1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [1:0]       mode;
    data_t            value;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    data_t element;
    logic  is_last;
    logic  list_empty;
    logic  insert_dropped;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_APPEND,
    CMD_DELETE,
    CMD_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
    data_t            value;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

@@ src/blid_cell.sv @@
// One storage cell of the list chain: holds one entry and takes data from
// its neighbors, the head cell or the new value as commanded.
// Depends on blid_pkg.
`default_nettype none

module blid_cell (
  input  wire                          clk_i,
  input  wire  [blid_pkg::IDX_W-1:0]   idx_i,
  input  blid_pkg::cell_ctl_t          ctl_i,
  input  blid_pkg::data_t              left_i,
  input  blid_pkg::data_t              right_i,
  input  blid_pkg::data_t              head_i,
  output blid_pkg::data_t              data_o
);
  import blid_pkg::*;

  data_t            data_q, data_d;
  logic [LEN_W-1:0] idx_len;
  logic [POS_W-1:0] idx_pos;

  assign idx_len = LEN_W'(idx_i);
  assign idx_pos = POS_W'(idx_i);

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.cmd)
      CMD_HOLD: data_d = data_q;
      CMD_PUSH_FRONT: begin
        data_d = (idx_i == '0) ? ctl_i.value : left_i;
      end
      CMD_APPEND: begin
        if (idx_len == ctl_i.len) data_d = ctl_i.value;
      end
      CMD_DELETE: begin
        if (idx_pos >= ctl_i.pos && (idx_len + LEN_W'(1)) < ctl_i.len) data_d = right_i;
      end
      CMD_ROTATE: begin
        if ((idx_len + LEN_W'(1)) == ctl_i.len) begin
          data_d = head_i;
        end else if (idx_len < ctl_i.len) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ src/blid_ctrl.sv @@
// Sequencer for the list chain: applies each operation, tracks the length,
// then rotates the chain once per word to stream the list out.
// Depends on blid_pkg.
`default_nettype none

module blid_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  blid_pkg::in_word_t     in_word_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output blid_pkg::out_word_t    out_word_o,
  input  blid_pkg::data_t        head_i,
  output blid_pkg::cell_ctl_t    ctl_o
);
  import blid_pkg::*;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_q, out_d;

  logic             accept;
  logic             can_load;
  logic             is_full;
  logic             is_del;
  logic             del_hit;
  logic             last_word;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign can_load  = !out_valid_q || out_ready_i;
  assign is_full   = (len_q == LEN_W'(CAPACITY));
  assign is_del    = in_word_i.mode[MODE_DELETE_BIT];
  assign del_hit   = in_word_i.position < POS_W'(len_q);
  assign last_word = (cnt_q + LEN_W'(1)) == len_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EMIT;
      ST_EMIT: if (can_load && (len_q == '0 || last_word)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready_o  = 1'b0;
    ctl_o.cmd   = CMD_HOLD;
    ctl_o.len   = len_q;
    ctl_o.pos   = in_word_i.position;
    ctl_o.value = in_word_i.value;
    len_d       = len_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (accept) begin
          drop_d = 1'b0;
          if (is_del) begin
            if (del_hit) begin
              ctl_o.cmd = CMD_DELETE;
              len_d     = len_q - LEN_W'(1);
            end
          end else if (is_full) begin
            drop_d = 1'b1;
          end else if (in_word_i.mode == MODE_FRONT) begin
            ctl_o.cmd = CMD_PUSH_FRONT;
            len_d     = len_q + LEN_W'(1);
          end else begin
            ctl_o.cmd = CMD_APPEND;
            len_d     = len_q + LEN_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_d          = 1'b1;
          out_d.insert_dropped = drop_q;
          if (len_q == '0) begin
            out_d.element    = '0;
            out_d.is_last    = 1'b1;
            out_d.list_empty = 1'b1;
          end else begin
            out_d.element    = head_i;
            out_d.is_last    = last_word;
            out_d.list_empty = 1'b0;
            ctl_o.cmd        = CMD_ROTATE;
            cnt_d            = cnt_q + LEN_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

@@ src/bounded_list_insert_delete_unit.sv @@
// Bounded list with insert front, append and delete at position.
// The first word is registered in the emit state that follows acceptance.
// A new item is taken only once the previous list has been streamed out, with
// the cell chain rotating one entry to the head per output word.
// Reset clears length and control; entry contents stay unset until written.
// Depends on blid_pkg, blid_ctrl and blid_cell.
`default_nettype none

module bounded_list_insert_delete_unit (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  blid_pkg::in_word_t     in_word_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output blid_pkg::out_word_t    out_word_o
);
  import blid_pkg::*;

  cell_ctl_t ctl;
  data_t     cell_data [CAPACITY];

  blid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .head_i      (cell_data[0]),
    .ctl_o       (ctl)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t left_w;
    data_t right_w;

    if (g == 0) begin : g_first
      assign left_w = ctl.value;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    blid_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

endmodule

`default_nettype wire

@@ bench/blid_list_checker.sv @@
`timescale 1ns / 100ps
// Checker for bounded_list_insert_delete_unit: keeps its own copy of the list,
// predicts the words that each accepted operation emits and compares them in order.
// Depends on blid_pkg.
module blid_list_checker (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_ready_i,
  input  blid_pkg::in_word_t   in_word_i,
  input  wire                  out_valid_i,
  input  wire                  out_ready_i,
  input  blid_pkg::out_word_t  out_word_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   words_o
);
  import blid_pkg::*;

  data_t     shadow_entries [CAPACITY];
  int        shadow_len;
  out_word_t list_words_due [$];
  int        mismatch_count = 0;
  int        word_count = 0;

  assign mismatches_o = mismatch_count;
  assign words_o      = word_count;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch, %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic apply_list_op(input in_word_t w);
    logic      dropped;
    out_word_t ow;
    int        i;
    dropped = 1'b0;
    if (w.mode[MODE_DELETE_BIT]) begin
      if (int'(w.position) < shadow_len) begin
        for (i = int'(w.position); i + 1 < shadow_len; i++) begin
          shadow_entries[i] = shadow_entries[i+1];
        end
        shadow_len--;
      end
    end else if (shadow_len >= CAPACITY) begin
      dropped = 1'b1;
    end else if (w.mode == MODE_FRONT) begin
      for (i = shadow_len; i > 0; i--) begin
        shadow_entries[i] = shadow_entries[i-1];
      end
      shadow_entries[0] = w.value;
      shadow_len++;
    end else begin
      shadow_entries[shadow_len] = w.value;
      shadow_len++;
    end
    if (shadow_len == 0) begin
      ow.element        = '0;
      ow.is_last        = 1'b1;
      ow.list_empty     = 1'b1;
      ow.insert_dropped = dropped;
      list_words_due.push_back(ow);
    end else begin
      for (i = 0; i < shadow_len; i++) begin
        ow.element        = shadow_entries[i];
        ow.is_last        = (i + 1 == shadow_len);
        ow.list_empty     = 1'b0;
        ow.insert_dropped = dropped;
        list_words_due.push_back(ow);
      end
    end
  endtask

  task automatic check_list_word(input out_word_t got);
    out_word_t want;
    word_count++;
    if (list_words_due.size() == 0) begin
      report("word with nothing due", 64'(got), 64'd0);
      return;
    end
    want = list_words_due.pop_front();
    if (got.element !== want.element)
      report("element", 64'(got.element), 64'(want.element));
    if (got.is_last !== want.is_last)
      report("is_last", 64'(got.is_last), 64'(want.is_last));
    if (got.list_empty !== want.list_empty)
      report("list_empty", 64'(got.list_empty), 64'(want.list_empty));
    if (got.insert_dropped !== want.insert_dropped)
      report("insert_dropped", 64'(got.insert_dropped), 64'(want.insert_dropped));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_words_due.delete();
      shadow_len = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_list_word(out_word_i);
      if (in_valid_i && in_ready_i) apply_list_op(in_word_i);
      pending_o <= list_words_due.size();
    end
  end

endmodule

@@ bench/tb_bounded_list_insert_delete_unit.sv @@
`timescale 1ns / 100ps
// Top of the bench for bounded_list_insert_delete_unit: drives list operations
// with random gaps and output stalls, and gives the verdict from blid_list_checker.
// Depends on blid_pkg, blid_list_checker and the unit itself.
module tb_bounded_list_insert_delete_unit;
  import blid_pkg::*;

  localparam int ITEMS    = 360;
  localparam int DIRECTED = 26;
  localparam int LIMIT    = 400000;
  localparam logic [1:0] OP_DELETE     = 2'd2;
  localparam logic [1:0] OP_DELETE_ALT = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_word;

  int mismatches;
  int pending_words;
  int words_seen;
  int cycle_count = 0;
  int fill_count = 0;
  int op_tally [4];
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  always #6 clk = ~clk;

  bounded_list_insert_delete_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  blid_list_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .mismatches_o (mismatches),
    .pending_o    (pending_words),
    .words_o      (words_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, pending_words);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic data_t pick_value();
    case ($urandom_range(0, 7))
      0: return data_t'(32'h8000_0000);
      1: return data_t'(32'h7fff_ffff);
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic send_op(input logic [1:0] m, input data_t v, input logic [POS_W-1:0] p);
    in_word_t w;
    w.mode     = m;
    w.value    = v;
    w.position = p;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    op_tally[m]++;
    if (m[MODE_DELETE_BIT]) begin
      if (int'(p) < fill_count) fill_count--;
    end else if (fill_count < CAPACITY) begin
      fill_count++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin
    int r;
    int insert_pct;
    logic [1:0] m;
    logic [POS_W-1:0] p;
    insert_pct = 50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, extreme values, deletes out of range, at the tail and via mode three
    send_op(OP_DELETE, data_t'($urandom), 8'd0);
    send_op(OP_DELETE_ALT, data_t'($urandom), 8'd0);
    send_op(MODE_FRONT, data_t'(32'h7fff_ffff), 8'd255);
    send_op(MODE_BACK, data_t'(32'h8000_0000), 8'd0);
    send_op(MODE_FRONT, data_t'(0), 8'd170);
    send_op(MODE_BACK, data_t'(32'hffff_ffff), 8'd85);
    send_op(OP_DELETE, data_t'($urandom), 8'd255);
    send_op(OP_DELETE, data_t'($urandom), 8'd4);
    send_op(OP_DELETE_ALT, data_t'($urandom), 8'd1);
    send_op(OP_DELETE, data_t'($urandom), 8'd2);
    // fill to capacity, then overfill from both ends
    for (int i = 0; i < 14; i++) begin
      send_op((i % 2) ? MODE_BACK : MODE_FRONT, pick_value(), 8'($urandom_range(0, 255)));
    end
    send_op(MODE_FRONT, pick_value(), 8'($urandom_range(0, 255)));
    send_op(MODE_BACK, pick_value(), 8'($urandom_range(0, 255)));
    drain();

    for (r = 0; r < ITEMS - DIRECTED; r++) begin
      if (r % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      if (r % 30 == 0) begin
        idle_on  = ($urandom_range(0, 2) != 0);
        stall_on = ($urandom_range(0, 2) != 0);
      end
      if (r >= ITEMS - DIRECTED - 60) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      if (r == 170) drain();
      if ($urandom_range(1, 100) <= insert_pct) begin
        m = $urandom_range(0, 1) ? MODE_BACK : MODE_FRONT;
        p = 8'($urandom_range(0, 255));
      end else begin
        m = ($urandom_range(0, 3) == 0) ? OP_DELETE_ALT : OP_DELETE;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6:
            p = (fill_count > 0) ? 8'($urandom_range(0, fill_count - 1))
                                 : 8'($urandom_range(0, 255));
          7, 8: p = 8'($urandom_range(fill_count, 255));
          default: p = 8'($urandom_range(0, 255));
        endcase
      end
      send_op(m, pick_value(), p);
    end
    in_valid <= 1'b0;

    drain();
    repeat (CAPACITY + 4) @(posedge clk);
    $display("covered %0d operations: %0d front, %0d back, %0d delete, %0d delete via mode three",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
             op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
    $display("compared %0d list words, %0d mismatches", words_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/blid_pkg.sv
src/blid_cell.sv
src/blid_ctrl.sv
src/bounded_list_insert_delete_unit.sv
bench/blid_list_checker.sv
bench/tb_bounded_list_insert_delete_unit.sv
